FILE: rtl/strict_priority_call_dispatcher_top_macros.svh
// Assertion helpers; both expect clk and rst_n in scope.
`ifndef STRICT_PRIORITY_CALL_DISPATCHER_TOP_MACROS_SVH
`define STRICT_PRIORITY_CALL_DISPATCHER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define SPCD_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spcd: same-cycle check failed");
`define SPCD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spcd: next-cycle check failed");
`else
`define SPCD_ASSERT_IMP(lbl, ante, cons)
`define SPCD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/spcd_pkg.sv
package spcd_pkg;

    localparam int NUM_CLASSES = 4;
    localparam int CLASS_W     = 2;
    localparam int ID_W        = 16;
    localparam int DUR_W       = 16;

    localparam int QUEUE_DEPTH_DEF   = 16;
    localparam int ID_BITS_DEF       = 16;
    localparam int DURATION_BITS_DEF = 16;

    // stream widths: input fields 34 bits, result fields 21 bits, padded to bytes
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;

    localparam logic ACT_ARRIVAL = 1'b0;
    localparam logic ACT_TICK    = 1'b1;

    typedef struct packed {
        logic               push_ok;
        logic               pick_valid;
        logic [CLASS_W-1:0] pick_class;
        logic               all_empty;
    } spcd_qstat_t;

endpackage

FILE: rtl/spcd_store.sv
module spcd_store #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [0:DEPTH-1];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/spcd_queue_ctrl.sv
module spcd_queue_ctrl #(
    parameter int QUEUE_DEPTH = spcd_pkg::QUEUE_DEPTH_DEF,
    parameter int IDX_W       = $clog2(QUEUE_DEPTH)
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 push,
    input  logic [spcd_pkg::CLASS_W-1:0]         push_class,
    input  logic                                 pop,
    output spcd_pkg::spcd_qstat_t                qstat,
    output logic [spcd_pkg::CLASS_W+IDX_W-1:0]   wr_addr,
    output logic [spcd_pkg::CLASS_W+IDX_W-1:0]   rd_addr
);

    import spcd_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [IDX_W-1:0] head_reg  [NUM_CLASSES];
    logic [IDX_W-1:0] head_next [NUM_CLASSES];
    logic [IDX_W-1:0] tail_reg  [NUM_CLASSES];
    logic [IDX_W-1:0] tail_next [NUM_CLASSES];
    logic [CNT_W-1:0] cnt_reg   [NUM_CLASSES];
    logic [CNT_W-1:0] cnt_next  [NUM_CLASSES];

    logic [NUM_CLASSES-1:0] full;
    logic [NUM_CLASSES-1:0] nonempty;
    logic                   pick_valid;
    logic [CLASS_W-1:0]     pick_class;
    logic                   push_fire;
    logic                   pop_fire;

    function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + IDX_W'(1);
    endfunction

    always_comb
    begin
        pick_valid = 1'b0;
        pick_class = '0;
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            full[c]     = (cnt_reg[c] == CNT_W'(QUEUE_DEPTH));
            nonempty[c] = (cnt_reg[c] != '0);
            // ascending scan: the highest nonempty class wins
            if (nonempty[c])
            begin
                pick_valid = 1'b1;
                pick_class = CLASS_W'(c);
            end
        end
    end

    assign push_fire = push && !full[push_class];
    assign pop_fire  = pop && pick_valid;

    always_comb
    begin
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            head_next[c] = head_reg[c];
            tail_next[c] = tail_reg[c];
            cnt_next[c]  = cnt_reg[c];
            if (push_fire && (push_class == CLASS_W'(c)))
            begin
                tail_next[c] = idx_next(tail_reg[c]);
                cnt_next[c]  = cnt_reg[c] + CNT_W'(1);
            end
            if (pop_fire && (pick_class == CLASS_W'(c)))
            begin
                head_next[c] = idx_next(head_reg[c]);
                cnt_next[c]  = cnt_reg[c] - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                head_reg[c] <= '0;
                tail_reg[c] <= '0;
                cnt_reg[c]  <= '0;
            end
        end
        else
        begin
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                head_reg[c] <= head_next[c];
                tail_reg[c] <= tail_next[c];
                cnt_reg[c]  <= cnt_next[c];
            end
        end
    end

    assign wr_addr = {push_class, tail_reg[push_class]};
    assign rd_addr = {pick_class, head_reg[pick_class]};

    assign qstat.push_ok    = !full[push_class];
    assign qstat.pick_valid = pick_valid;
    assign qstat.pick_class = pick_class;
    assign qstat.all_empty  = (nonempty == '0);

endmodule

FILE: rtl/strict_priority_call_dispatcher_top.sv
// Arrival transaction: accepted whenever the dispatcher is idle, produces no result.
// Tick transaction: the response state reads the registered queue store output and loads
// the output register, later while the previous result waits for the receiver; next item
// taken every cycle after an arrival, after a tick only once the response state is left.
// Reset (async, active low) clears queue pointers, counts, busy counter, drop
// flag and handshake state; queue store contents are left as they are.
module strict_priority_call_dispatcher_top #(
    parameter int QUEUE_DEPTH   = spcd_pkg::QUEUE_DEPTH_DEF,
    parameter int ID_BITS       = spcd_pkg::ID_BITS_DEF,
    parameter int DURATION_BITS = spcd_pkg::DURATION_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // caller_id[15:0], priority_class[17:16], service_ticks[33:18], zero pad
    input  logic [spcd_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // action[0]
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // answered[0], answered_id[16:1], answered_class[18:17], all_idle[19],
    // dropped_flag[20], zero pad
    output logic [spcd_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    import spcd_pkg::*;

    `include "strict_priority_call_dispatcher_top_macros.svh"

    localparam int IDX_W  = $clog2(QUEUE_DEPTH);
    localparam int ADDR_W = CLASS_W + IDX_W;
    localparam int DATA_W = ID_BITS + DURATION_BITS;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RESP = 1'b1;

    logic state_reg, state_next;
    logic [DURATION_BITS-1:0] busy_reg, busy_next;
    logic drop_reg, drop_next;
    logic pick_valid_reg, pick_valid_next;
    logic [CLASS_W-1:0] pick_class_reg, pick_class_next;
    logic m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic               in_fire;
    logic               push;
    logic               tick_fire;
    logic               pop;
    logic [ID_W-1:0]    in_id;
    logic [CLASS_W-1:0] in_class;
    logic [DUR_W-1:0]   in_dur;
    logic [31:0]        id_ext;
    logic [31:0]        dur_ext;
    logic [DATA_W-1:0]  wr_data;
    logic [DATA_W-1:0]  rd_data;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    spcd_qstat_t        qstat;

    logic [ID_BITS-1:0]       rd_id;
    logic [DURATION_BITS-1:0] rd_dur;
    logic [31:0]              rd_id_ext;
    logic [DURATION_BITS-1:0] busy_load;
    logic                     out_free;
    logic [ID_W-1:0]          ans_id;
    logic [CLASS_W-1:0]       ans_class;
    logic                     all_idle;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign in_id     = s_axis_tdata[ID_W-1:0];
    assign in_class  = s_axis_tdata[ID_W+CLASS_W-1:ID_W];
    assign in_dur    = s_axis_tdata[ID_W+CLASS_W+DUR_W-1:ID_W+CLASS_W];
    assign push      = in_fire && (s_axis_tuser == ACT_ARRIVAL);
    assign tick_fire = in_fire && (s_axis_tuser == ACT_TICK);
    assign pop       = tick_fire && (busy_reg == '0);

    assign id_ext  = 32'(in_id);
    assign dur_ext = 32'(in_dur);
    assign wr_data = {dur_ext[DURATION_BITS-1:0], id_ext[ID_BITS-1:0]};

    spcd_queue_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_queue_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_class (in_class),
        .pop        (pop),
        .qstat      (qstat),
        .wr_addr    (wr_addr),
        .rd_addr    (rd_addr)
    );

    spcd_store #(
        .ADDR_W (ADDR_W),
        .DATA_W (DATA_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (push && qstat.push_ok),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (pop),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_id     = rd_data[ID_BITS-1:0];
    assign rd_dur    = rd_data[DATA_W-1:ID_BITS];
    assign rd_id_ext = 32'(rd_id);

    // response stage: load the popped duration if a call was picked, then count one tick down
    assign out_free  = !m_tvalid_reg || m_axis_tready;
    assign busy_load = pick_valid_reg ? rd_dur : busy_reg;
    assign ans_id    = pick_valid_reg ? rd_id_ext[ID_W-1:0] : '0;
    assign ans_class = pick_valid_reg ? pick_class_reg : '0;

    always_comb
    begin
        state_next      = state_reg;
        busy_next       = busy_reg;
        drop_next       = drop_reg;
        pick_valid_next = pick_valid_reg;
        pick_class_next = pick_class_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        all_idle        = 1'b0;

        if (m_tvalid_reg && m_axis_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (push && !qstat.push_ok)
                begin
                    drop_next = 1'b1;
                end
                if (tick_fire)
                begin
                    pick_valid_next = pop && qstat.pick_valid;
                    pick_class_next = qstat.pick_class;
                    state_next      = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    busy_next = (busy_load != '0) ? busy_load - DURATION_BITS'(1) : busy_load;
                    all_idle  = (busy_next == '0) && qstat.all_empty;
                    m_tdata_next = M_TDATA_W'({drop_reg, all_idle, ans_class, ans_id,
                                               pick_valid_reg});
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            busy_reg       <= '0;
            drop_reg       <= 1'b0;
            pick_valid_reg <= 1'b0;
            pick_class_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            busy_reg       <= busy_next;
            drop_reg       <= drop_next;
            pick_valid_reg <= pick_valid_next;
            pick_class_reg <= pick_class_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;

    `SPCD_ASSERT_NEXT(a_tick_to_resp, tick_fire, state_reg == ST_RESP)
    `SPCD_ASSERT_NEXT(a_no_pop_while_busy, tick_fire && (busy_reg != '0), !pick_valid_reg)
    `SPCD_ASSERT_NEXT(a_drop_sticky, drop_reg, drop_reg)
    `SPCD_ASSERT_IMP(a_unanswered_zero, m_tvalid_reg && !m_tdata_reg[0], m_tdata_reg[18:1] == '0)

endmodule

FILE: verif/spcd_dispatch_checker.sv
`timescale 1ns / 1ps

module spcd_dispatch_checker
    import spcd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tready,
    // caller_id[15:0], priority_class[17:16], service_ticks[33:18], zero pad
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // action[0]
    input  logic                 s_axis_tuser,
    input  logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // answered[0], answered_id[16:1], answered_class[18:17], all_idle[19],
    // dropped_flag[20], zero pad
    input  logic [M_TDATA_W-1:0] m_axis_tdata,
    output int                   fail_count,
    output int                   pending_count
);

    localparam int DEPTH = QUEUE_DEPTH_DEF;
    localparam int IDX_W = $clog2(DEPTH);

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [DUR_W-1:0] dur;
    } call_t;

    // packed MSB first, so the layout matches the master tdata bits
    typedef struct packed {
        logic               dropped;
        logic               idle;
        logic [CLASS_W-1:0] cls;
        logic [ID_W-1:0]    id;
        logic               answered;
    } dispatch_result_t;

    call_t            call_store [NUM_CLASSES][DEPTH];
    logic [IDX_W-1:0] head_ptr   [NUM_CLASSES];
    logic [IDX_W-1:0] tail_ptr   [NUM_CLASSES];
    logic [IDX_W:0]   occupancy  [NUM_CLASSES];
    logic [DUR_W-1:0] busy_ticks;
    logic             drop_seen;

    dispatch_result_t pending_answers [$];
    dispatch_result_t want;
    dispatch_result_t got;

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
        return (int'(idx) + 1 >= DEPTH) ? '0 : idx + 1'b1;
    endfunction

    task automatic enqueue_call(input logic [CLASS_W-1:0] cls, input logic [ID_W-1:0] id,
                                input logic [DUR_W-1:0] dur);
        if (int'(occupancy[cls]) >= DEPTH) begin
            drop_seen = 1'b1;
        end
        else begin
            call_store[cls][tail_ptr[cls]] = '{id: id, dur: dur};
            tail_ptr[cls]  = next_slot(tail_ptr[cls]);
            occupancy[cls] = occupancy[cls] + 1'b1;
        end
    endtask

    task automatic dispatch_tick(output dispatch_result_t res);
        logic  found;
        call_t head;
        res   = '0;
        found = 1'b0;
        // server free: take the head of the highest nonempty class
        if (busy_ticks == '0) begin
            for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
                if (!found && occupancy[c] != '0) begin
                    head         = call_store[c][head_ptr[c]];
                    found        = 1'b1;
                    res.answered = 1'b1;
                    res.id       = head.id;
                    res.cls      = CLASS_W'(c);
                    busy_ticks   = head.dur;
                    head_ptr[c]  = next_slot(head_ptr[c]);
                    occupancy[c] = occupancy[c] - 1'b1;
                end
            end
        end
        if (busy_ticks != '0)
            busy_ticks = busy_ticks - 1'b1;
        res.idle = (busy_ticks == '0);
        for (int c = 0; c < NUM_CLASSES; c++)
            if (occupancy[c] != '0)
                res.idle = 1'b0;
        res.dropped = drop_seen;
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                head_ptr[c]  = '0;
                tail_ptr[c]  = '0;
                occupancy[c] = '0;
            end
            busy_ticks = '0;
            drop_seen  = 1'b0;
            pending_answers.delete();
            fail_count    = 0;
            pending_count = 0;
        end
        else begin
            // results first: anything accepted now belongs to an older tick
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[$bits(dispatch_result_t)-1:0];
                if (pending_answers.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("[%0t] unexpected result transaction: answered=%0d id=%h",
                                 $realtime, got.answered, got.id,
                                 " class=%0d idle=%0d drop=%0d",
                                 got.cls, got.idle, got.dropped);
                end
                else begin
                    want = pending_answers.pop_front();
                    if (got.answered !== want.answered || got.id !== want.id ||
                        got.cls !== want.cls || got.idle !== want.idle ||
                        got.dropped !== want.dropped) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("[%0t] tick result mismatch: exp answered=%0d id=%h",
                                     $realtime, want.answered, want.id,
                                     " class=%0d idle=%0d drop=%0d | got answered=%0d",
                                     want.cls, want.idle, want.dropped, got.answered,
                                     " id=%h class=%0d idle=%0d drop=%0d",
                                     got.id, got.cls, got.idle, got.dropped);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == ACT_TICK) begin
                    dispatch_tick(want);
                    pending_answers.push_back(want);
                end
                else begin
                    enqueue_call(s_axis_tdata[17:16], s_axis_tdata[15:0],
                                 s_axis_tdata[33:18]);
                end
            end
            pending_count = pending_answers.size();
        end
    end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import spcd_pkg::*;

    localparam logic [CLASS_W-1:0] CLS_REGULAR  = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_SILVER   = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_GOLD     = 2'd2;
    localparam logic [CLASS_W-1:0] CLS_PLATINUM = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    // caller_id[15:0], priority_class[17:16], service_ticks[33:18], zero pad
    logic [S_TDATA_W-1:0] s_axis_tdata;
    // action[0]
    logic                 s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // answered[0], answered_id[16:1], answered_class[18:17], all_idle[19],
    // dropped_flag[20], zero pad
    logic [M_TDATA_W-1:0] m_axis_tdata;

    int fail_count;
    int pending_count;
    int send_idle_pct;
    int recv_idle_pct;

    strict_priority_call_dispatcher_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    spcd_dispatch_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // valid is only lowered during a gap, so it never toggles within one step
    task automatic drive_item(input logic act, input logic [ID_W-1:0] id,
                              input logic [CLASS_W-1:0] cls, input logic [DUR_W-1:0] dur);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {{(S_TDATA_W - 34){1'b0}}, dur, cls, id};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_arrival(input logic [ID_W-1:0] id, input logic [CLASS_W-1:0] cls,
                                input logic [DUR_W-1:0] dur);
        drive_item(ACT_ARRIVAL, id, cls, dur);
    endtask

    // the other fields are don't-care on a tick, so fill them with noise
    task automatic send_tick();
        drive_item(ACT_TICK, ID_W'($urandom), CLASS_W'($urandom), DUR_W'($urandom));
    endtask

    // short service times keep the queues moving
    function automatic logic [DUR_W-1:0] pick_duration();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return DUR_W'($urandom_range(0, 2));
        else if (r < 95)
            return DUR_W'($urandom_range(3, 12));
        return DUR_W'($urandom_range(13, 40));
    endfunction

    task automatic run_random(input int n_items);
        int                 sent;
        int                 pick;
        int                 burst;
        logic [CLASS_W-1:0] cls;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                if ($urandom_range(0, 1))
                    send_tick();
                else
                    send_arrival(ID_W'($urandom), CLASS_W'($urandom), pick_duration());
                sent++;
            end
            else if (pick < 75) begin
                // arrival burst into one class, long ones overflow it
                burst = $urandom_range(4, 20);
                cls   = CLASS_W'($urandom);
                repeat (burst)
                    send_arrival(ID_W'($urandom), cls, pick_duration());
                sent += burst;
            end
            else begin
                burst = $urandom_range(4, 30);
                repeat (burst)
                    send_tick();
                sent += burst;
            end
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = ACT_ARRIVAL;
        send_idle_pct = 19;
        recv_idle_pct = 46;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty dispatcher
        send_tick();
        // priority order, unit and zero service times, id extremes
        send_arrival(16'hFFFF, CLS_PLATINUM, 16'd1);
        send_arrival(16'h0000, CLS_GOLD, 16'd0);
        send_arrival(16'h5A5A, CLS_REGULAR, 16'd2);
        repeat (4) send_tick();
        // overflow one class: last arrival is dropped
        for (int i = 0; i < QUEUE_DEPTH_DEF + 1; i++)
            send_arrival(ID_W'(16'h0100 + i), CLS_SILVER, 16'd0);
        send_tick();

        run_random(250);
        send_idle_pct = 46;
        recv_idle_pct = 19;
        run_random(250);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(250);

        // wide service times, left in service at the end of the run
        send_arrival(ID_W'($urandom), CLS_PLATINUM, 16'hFFFF);
        repeat (3)
            send_arrival(ID_W'($urandom), CLASS_W'($urandom), DUR_W'($urandom));
        repeat (40) send_tick();

        s_axis_tvalid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/spcd_pkg.sv
rtl/spcd_store.sv
rtl/spcd_queue_ctrl.sv
rtl/strict_priority_call_dispatcher_top.sv
verif/spcd_dispatch_checker.sv
verif/tb.sv
